// ===== sv/aesrr_pkg.sv =====
// aesrr_pkg: shared types, constants and functions for the reduced-round AES-128 core
// depends on nothing

package aesrr_pkg;

    localparam int unsigned BLOCK_W      = 128;
    localparam int unsigned HALF_W       = 64;
    localparam int unsigned ROUND_CNT_W  = 4;
    localparam logic [3:0]  MAX_ROUNDS   = 4'd10;
    localparam logic [3:0]  ROUNDS_RESET = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       step;
        logic       last_round;
        logic [3:0] rnd;
    } dp_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // round constant for rounds 1..10, index is round minus one
    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== sv/aesrr_if.sv =====
// aesrr_in_if / aesrr_out_if: valid/ready channels of the core
// depends on nothing

interface aesrr_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] plaintext_high;
    logic [63:0] plaintext_low;
    logic [63:0] key_high;
    logic [63:0] key_low;

    modport source (output valid, plaintext_high, plaintext_low, key_high, key_low,
                    input ready);
    modport sink   (input valid, plaintext_high, plaintext_low, key_high, key_low,
                    output ready);
endinterface

interface aesrr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;

    modport source (output valid, ciphertext_high, ciphertext_low, input ready);
    modport sink   (input valid, ciphertext_high, ciphertext_low, output ready);
endinterface

// ===== sv/aesrr_ctrl.sv =====
// aesrr_ctrl: round sequencer for the reduced-round AES core
// depends on aesrr_pkg

module aesrr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          rounds,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output aesrr_pkg::dp_cmd_t  cmd
);

    aesrr_pkg::ctrl_state_t state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;
    logic [3:0] target_reg, target_next;

    // state and round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= aesrr_pkg::ST_IDLE;
            rnd_reg    <= 4'd0;
            target_reg <= 4'd0;
        end
        else
        begin
            state_reg  <= state_next;
            rnd_reg    <= rnd_next;
            target_reg <= target_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        target_next    = target_reg;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.rnd        = rnd_reg;
        cmd.last_round = (rnd_reg == aesrr_pkg::MAX_ROUNDS - 4'd1);
        case (state_reg)
            aesrr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    rnd_next    = 4'd0;
                    target_next = (rounds > aesrr_pkg::MAX_ROUNDS) ?
                                  aesrr_pkg::MAX_ROUNDS : rounds;
                    state_next  = (target_next == 4'd0) ? aesrr_pkg::ST_OUT
                                                        : aesrr_pkg::ST_ROUND;
                end
            end
            aesrr_pkg::ST_ROUND:
            begin
                cmd.step = 1'b1;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_next == target_reg)
                    state_next = aesrr_pkg::ST_OUT;
            end
            aesrr_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                // result register frees as it drains, so accept the next beat too
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load    = 1'b1;
                        rnd_next    = 4'd0;
                        target_next = (rounds > aesrr_pkg::MAX_ROUNDS) ?
                                      aesrr_pkg::MAX_ROUNDS : rounds;
                        state_next  = (target_next == 4'd0) ? aesrr_pkg::ST_OUT
                                                            : aesrr_pkg::ST_ROUND;
                    end
                    else
                    begin
                        state_next = aesrr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = aesrr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/aesrr_dp.sv =====
// aesrr_dp: state and round-key registers with one AES round per cycle
// depends on aesrr_pkg

module aesrr_dp
(
    input  logic               clk,
    input  aesrr_pkg::dp_cmd_t cmd,
    input  logic [127:0]       plaintext,
    input  logic [127:0]       key,
    output logic [127:0]       state_out
);

    logic [127:0] state_reg, state_next;
    logic [127:0] key_reg, key_next;
    logic [7:0]   s [16];
    logic [7:0]   k [16];
    logic [7:0]   t [16];
    logic [7:0]   m [16];
    logic [7:0]   nk [16];
    logic [7:0]   kt [4];

    // byte views, byte 0 most significant
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_reg[127 - 8*i -: 8];
            k[i] = key_reg[127 - 8*i -: 8];
        end
    end

    // next round key
    always_comb
    begin
        kt[0] = aesrr_pkg::SBOX[k[13]] ^ aesrr_pkg::rcon(cmd.rnd);
        kt[1] = aesrr_pkg::SBOX[k[14]];
        kt[2] = aesrr_pkg::SBOX[k[15]];
        kt[3] = aesrr_pkg::SBOX[k[12]];
        for (int i = 0; i < 4; i++)
            nk[i] = k[i] ^ kt[i];
        for (int i = 4; i < 16; i++)
            nk[i] = k[i] ^ nk[i - 4];
    end

    // sub bytes and shift rows
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4*c] = aesrr_pkg::SBOX[s[r + 4*((c + r) % 4)]];
    end

    // mix columns, skipped only in round ten
    always_comb
    begin
        logic [7:0] all;
        for (int c = 0; c < 4; c++)
        begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int r = 0; r < 4; r++)
                m[4*c + r] = cmd.last_round ? t[4*c + r] :
                    (t[4*c + r] ^ all ^
                     aesrr_pkg::xtime(t[4*c + r] ^ t[4*c + ((r + 1) % 4)]));
        end
    end

    // register updates
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        if (cmd.load)
        begin
            state_next = plaintext ^ key;
            key_next   = key;
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < 16; i++)
            begin
                state_next[127 - 8*i -: 8] = m[i] ^ nk[i];
                key_next[127 - 8*i -: 8]   = nk[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
    end

    assign state_out = state_reg;

endmodule

// ===== sv/aes128_reduced_round_encrypt_core.sv =====
// aes128_reduced_round_encrypt_core: top level of the reduced-round AES-128 core
// depends on aesrr_pkg, aesrr_if, aesrr_ctrl, aesrr_dp
//
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     plaintext_high, plaintext_low, key_high, key_low
//  out_ch    out  valid/ready     ciphertext_high, ciphertext_low
//  cfg       in   cfg_we          cfg_wdata[3:0] = round_count
//
// an item is loaded and then runs n rounds, n = round_count saturated at 10, on the shared
// round unit doing one round and one key expansion step per cycle.
// the result is held in the state register until taken; a new beat is accepted
// in the same cycle the result is taken.
// reset clears the controller and sets round_count to 10.

module aes128_reduced_round_encrypt_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    aesrr_in_if.sink    in_ch,
    aesrr_out_if.source out_ch
);

    logic [3:0]         round_count_reg;
    aesrr_pkg::dp_cmd_t cmd;
    logic [127:0]       state_out;

    // round count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            round_count_reg <= aesrr_pkg::ROUNDS_RESET;
        else if (cfg_we)
            round_count_reg <= cfg_wdata;
    end

    aesrr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rounds    (round_count_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    aesrr_dp u_dp
    (
        .clk       (clk),
        .cmd       (cmd),
        .plaintext ({in_ch.plaintext_high, in_ch.plaintext_low}),
        .key       ({in_ch.key_high, in_ch.key_low}),
        .state_out (state_out)
    );

    assign out_ch.ciphertext_high = state_out[127:64];
    assign out_ch.ciphertext_low  = state_out[63:0];

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for the reduced-round AES-128 core
// depends on aesrr_pkg, aesrr_if and aes128_reduced_round_encrypt_core
// beats go in through a queued driver and are checked against a local cipher predictor
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic [63:0] pt_hi;
        logic [63:0] pt_lo;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } block_beat_t;

    typedef struct {
        logic [63:0] ct_hi;
        logic [63:0] ct_lo;
    } cipher_beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_wdata;

    aesrr_in_if  in_ch ();
    aesrr_out_if out_ch ();

    aes128_reduced_round_encrypt_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    block_beat_t  pending_blocks[$];
    cipher_beat_t expected_ciphers[$];
    logic [3:0]   model_rounds;
    int           errors = 0;
    int           cycle_cnt = 0;
    int           send_gap;
    int           recv_gap;
    int           hold_off;
    bit           long_stall_req = 1'b0;
    bit           long_stall_done;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] dbl(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // expected cipher state after the programmed number of rounds
    function automatic cipher_beat_t cipher_rounds(block_beat_t b, logic [3:0] rounds);
        logic [7:0]   st[16];
        logic [7:0]   rk[16];
        logic [7:0]   tmp[16];
        logic [7:0]   t[4];
        logic [7:0]   a0, a1, a2, a3, all;
        logic [7:0]   rc[10];
        int           n;
        cipher_beat_t res;
        rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
        n = (rounds > 10) ? 10 : rounds;
        for (int i = 0; i < 8; i++)
        begin
            st[i]     = b.pt_hi[63 - 8 * i -: 8];
            st[i + 8] = b.pt_lo[63 - 8 * i -: 8];
            rk[i]     = b.key_hi[63 - 8 * i -: 8];
            rk[i + 8] = b.key_lo[63 - 8 * i -: 8];
        end
        for (int i = 0; i < 16; i++)
            st[i] ^= rk[i];
        for (int r = 1; r <= n; r++)
        begin
            // key schedule step
            t[0] = aesrr_pkg::SBOX[rk[13]] ^ rc[r - 1];
            t[1] = aesrr_pkg::SBOX[rk[14]];
            t[2] = aesrr_pkg::SBOX[rk[15]];
            t[3] = aesrr_pkg::SBOX[rk[12]];
            for (int i = 0; i < 4; i++)
                rk[i] ^= t[i];
            for (int i = 4; i < 16; i++)
                rk[i] ^= rk[i - 4];
            // sub bytes and shift rows
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    tmp[w + 4 * c] = aesrr_pkg::SBOX[st[w + 4 * ((c + w) % 4)]];
            st = tmp;
            // mix columns except in round ten
            if (r != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[4 * c]; a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c]     = a0 ^ all ^ dbl(a0 ^ a1);
                    st[4 * c + 1] = a1 ^ all ^ dbl(a1 ^ a2);
                    st[4 * c + 2] = a2 ^ all ^ dbl(a2 ^ a3);
                    st[4 * c + 3] = a3 ^ all ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] ^= rk[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            res.ct_hi[63 - 8 * i -: 8] = st[i];
            res.ct_lo[63 - 8 * i -: 8] = st[i + 8];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h1;
            default: return rand64();
        endcase
    endfunction

    task automatic push_block(logic [63:0] ph, logic [63:0] pl, logic [63:0] kh,
                              logic [63:0] kl);
        block_beat_t b;
        b.pt_hi = ph; b.pt_lo = pl; b.key_hi = kh; b.key_lo = kl;
        pending_blocks.push_back(b);
    endtask

    // settled check away from the rising edge: nothing queued, offered or in flight
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_blocks.size() != 0 || in_ch.valid || expected_ciphers.size() != 0);
    endtask

    // wait for the core to drain, then program the round count
    task automatic set_rounds(logic [3:0] value);
        wait_idle();
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_rounds = value;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid          <= 1'b0;
            in_ch.plaintext_high <= '0;
            in_ch.plaintext_low  <= '0;
            in_ch.key_high       <= '0;
            in_ch.key_low        <= '0;
            send_gap             <= 0;
        end
        else if (in_ch.valid && !in_ch.ready)
        begin
        end
        else if (send_gap > 0)
        begin
            in_ch.valid <= 1'b0;
            send_gap    <= send_gap - 1;
        end
        else if (pending_blocks.size() > 0)
        begin
            block_beat_t b;
            b = pending_blocks.pop_front();
            in_ch.valid          <= 1'b1;
            in_ch.plaintext_high <= b.pt_hi;
            in_ch.plaintext_low  <= b.pt_lo;
            in_ch.key_high       <= b.key_hi;
            in_ch.key_low        <= b.key_lo;
            send_gap             <= pick_gap();
        end
        else
            in_ch.valid <= 1'b0;
    end

    // predict on every accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            block_beat_t b;
            b.pt_hi  = in_ch.plaintext_high;
            b.pt_lo  = in_ch.plaintext_low;
            b.key_hi = in_ch.key_high;
            b.key_lo = in_ch.key_low;
            expected_ciphers.push_back(cipher_rounds(b, model_rounds));
        end
    end

    // output ready, with one long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready    <= 1'b0;
            recv_gap        <= 0;
            hold_off        <= 0;
            long_stall_done <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off     <= hold_off - 1;
        end
        else if (long_stall_req && !long_stall_done)
        begin
            out_ch.ready    <= 1'b0;
            hold_off        <= 300;
            long_stall_done <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            recv_gap     <= recv_gap - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            recv_gap     <= pick_gap();
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            cipher_beat_t e;
            if (expected_ciphers.size() == 0)
            begin
                $display("%0t: unexpected beat actual %h_%h", $time,
                         out_ch.ciphertext_high, out_ch.ciphertext_low);
                errors++;
            end
            else
            begin
                e = expected_ciphers.pop_front();
                if (out_ch.ciphertext_high !== e.ct_hi)
                begin
                    $display("%0t: ciphertext_high expected %h actual %h", $time,
                             e.ct_hi, out_ch.ciphertext_high);
                    errors++;
                end
                if (out_ch.ciphertext_low !== e.ct_lo)
                begin
                    $display("%0t: ciphertext_low expected %h actual %h", $time,
                             e.ct_lo, out_ch.ciphertext_low);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > 400000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [3:0] phase_rounds[6];
        model_rounds = aesrr_pkg::ROUNDS_RESET;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset round count, known vector, field extremes
        push_block(64'h3243f6a8885a308d, 64'h313198a2e0370734,
                   64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        push_block('0, '0, '0, '0);
        push_block('1, '1, '1, '1);
        push_block('1, '0, '0, '1);
        push_block(64'h0011223344556677, 64'h8899aabbccddeeff,
                   64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        // zero rounds gives plaintext xor key
        set_rounds(4'd0);
        push_block(64'h0011223344556677, 64'h8899aabbccddeeff, '1, '0);
        push_block('1, '1, '1, '1);
        // saturating counts above ten
        set_rounds(4'd15);
        push_block(64'h0011223344556677, 64'h8899aabbccddeeff,
                   64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        push_block('0, '1, '0, '1);
        set_rounds(4'd11);
        push_block(rand64(), rand64(), rand64(), rand64());
        // a single full round and nine rounds
        set_rounds(4'd1);
        push_block(edge64(), edge64(), edge64(), edge64());
        set_rounds(4'd9);
        push_block(edge64(), edge64(), edge64(), edge64());

        // random phases; the receiver stalls long in the first one
        phase_rounds = '{4'd10, 4'd0, 4'd5, 4'd15, 4'd2, 4'd7};
        for (int p = 0; p < 6; p++)
        begin
            set_rounds(p == 0 ? 4'd10 : ($urandom_range(0, 1) ? phase_rounds[p]
                                          : 4'($urandom_range(0, 15))));
            if (p == 0)
                long_stall_req = 1'b1;
            for (int i = 0; i < 225; i++)
                push_block(edge64(), edge64(), edge64(), edge64());
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
